// ===== design/pwad_pkg.sv =====
package pwad_pkg;

    localparam int READ_WINDOWS_DEF  = 16;
    localparam int WRITE_WINDOWS_DEF = 16;

    // item modes
    localparam logic [2:0] MODE_LOOKUP_RD = 3'd0;
    localparam logic [2:0] MODE_LOOKUP_WR = 3'd1;
    localparam logic [2:0] MODE_SET_RD    = 3'd2;
    localparam logic [2:0] MODE_SET_WR    = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;

    // fixed map targets
    localparam logic [4:0] TGT_OPEN           = 5'd0;
    localparam logic [4:0] TGT_RAM            = 5'd1;
    localparam logic [4:0] TGT_RAM_MIRROR     = 5'd2;
    localparam logic [4:0] TGT_VID_REG_RD     = 5'd3;
    localparam logic [4:0] TGT_VID_STATUS     = 5'd4;
    localparam logic [4:0] TGT_VID_DATA       = 5'd5;
    localparam logic [4:0] TGT_SND_STATUS_RD  = 5'd6;
    localparam logic [4:0] TGT_JOYPAD_RD      = 5'd7;
    localparam logic [4:0] TGT_DISK_REG_BASE  = 5'd8;
    localparam logic [4:0] TGT_DISK_WAVE_RD   = 5'd12;
    localparam logic [4:0] TGT_DISK_SND_RD    = 5'd13;
    localparam logic [4:0] TGT_VID_REG_WR     = 5'd14;
    localparam logic [4:0] TGT_SND_WR         = 5'd22;
    localparam logic [4:0] TGT_DMC            = 5'd23;
    localparam logic [4:0] TGT_SPRITE_DMA     = 5'd24;
    localparam logic [4:0] TGT_SND_STATUS_WR  = 5'd25;
    localparam logic [4:0] TGT_JOY_STROBE     = 5'd26;
    localparam logic [4:0] TGT_FRAME_CNT      = 5'd27;
    localparam logic [4:0] TGT_DISK_WAVE_WR   = 5'd28;
    localparam logic [4:0] TGT_DISK_SND_WR    = 5'd29;

    localparam logic [15:0] RAM_MASK      = 16'h07FF;
    localparam logic [15:0] ADDR_DMC      = 16'h4010;
    localparam logic [15:0] ADDR_SPR_DMA  = 16'h4014;
    localparam logic [15:0] ADDR_SND_STAT = 16'h4015;
    localparam logic [15:0] ADDR_JOY1     = 16'h4016;
    localparam logic [15:0] ADDR_JOY2     = 16'h4017;
    localparam logic [15:0] ADDR_DISK_REG = 16'h4030;
    localparam logic [15:0] ADDR_DISK_END = 16'h4033;
    localparam logic [15:0] ADDR_WAVE     = 16'h4040;
    localparam logic [15:0] ADDR_DISK_SND = 16'h4080;
    localparam logic [15:0] ADDR_SND_WEND = 16'h408A;
    localparam logic [15:0] ADDR_SND_RD   = 16'h4090;
    localparam logic [15:0] ADDR_SND_REND = 16'h4092;

    localparam logic [2:0] VID_REG_STATUS = 3'd2;
    localparam logic [2:0] VID_REG_DATA   = 3'd7;

    // query handed from cell to cell
    typedef struct packed {
        logic        vld;
        logic        is_set;
        logic [15:0] addr;
        logic [15:0] end_addr;
        logic [7:0]  handler;
        logic        hit;
        logic [7:0]  id;
        logic        appended;
    } token_t;

    function automatic logic [4:0] fixed_read(input logic [15:0] a);
        logic [4:0] bank;
        logic [4:0] t;
        bank = a[15:11];
        t    = TGT_OPEN;
        if (a <= RAM_MASK) begin
            t = TGT_RAM;
        end else if (bank <= 5'd3) begin
            t = TGT_RAM_MIRROR;
        end else if (bank <= 5'd7) begin
            if (a[2:0] == VID_REG_STATUS) begin
                t = TGT_VID_STATUS;
            end else if (a[2:0] == VID_REG_DATA) begin
                t = TGT_VID_DATA;
            end else begin
                t = TGT_VID_REG_RD;
            end
        end else if (bank == 5'd8) begin
            if (a == ADDR_SND_STAT) begin
                t = TGT_SND_STATUS_RD;
            end else if (a == ADDR_JOY1 || a == ADDR_JOY2) begin
                t = TGT_JOYPAD_RD;
            end else if (a >= ADDR_DISK_REG && a <= ADDR_DISK_END) begin
                t = TGT_DISK_REG_BASE + {3'd0, a[1:0]};
            end else if (a >= ADDR_WAVE && a < ADDR_DISK_SND) begin
                t = TGT_DISK_WAVE_RD;
            end else if (a >= ADDR_SND_RD && a <= ADDR_SND_REND) begin
                t = TGT_DISK_SND_RD;
            end
        end
        return t;
    endfunction

    function automatic logic [4:0] fixed_write(input logic [15:0] a);
        logic [4:0] bank;
        logic [4:0] t;
        bank = a[15:11];
        t    = TGT_OPEN;
        if (a <= RAM_MASK) begin
            t = TGT_RAM;
        end else if (bank <= 5'd3) begin
            t = TGT_RAM_MIRROR;
        end else if (bank <= 5'd7) begin
            t = TGT_VID_REG_WR + {2'd0, a[2:0]};
        end else if (bank == 5'd8) begin
            if (a < ADDR_DMC) begin
                t = TGT_SND_WR;
            end else if (a < ADDR_SPR_DMA) begin
                t = TGT_DMC;
            end else if (a == ADDR_SPR_DMA) begin
                t = TGT_SPRITE_DMA;
            end else if (a == ADDR_SND_STAT) begin
                t = TGT_SND_STATUS_WR;
            end else if (a == ADDR_JOY1) begin
                t = TGT_JOY_STROBE;
            end else if (a == ADDR_JOY2) begin
                t = TGT_FRAME_CNT;
            end else if (a >= ADDR_WAVE && a < ADDR_DISK_SND) begin
                t = TGT_DISK_WAVE_WR;
            end else if (a >= ADDR_DISK_SND && a <= ADDR_SND_WEND) begin
                t = TGT_DISK_SND_WR;
            end
        end
        return t;
    endfunction

endpackage

// ===== design/programmable_window_address_decoder_unit.sv =====
// A lookup or set transfer is registered into the launch register of the addressed table
// (READ_WINDOWS or WRITE_WINDOWS window cells); the query walks the row of window cells
// one cell per cycle and done is registered from the last cell's result. Clear and unused
// modes answer next cycle. Busy holds off starts until done; one clear per cycle when idle.
// Reset: both window counts go to zero, the block is idle; window contents stay unknown.
// Results cannot be stalled: done marks a single-cycle result.
module programmable_window_address_decoder_unit #(
    parameter int READ_WINDOWS  = pwad_pkg::READ_WINDOWS_DEF,
    parameter int WRITE_WINDOWS = pwad_pkg::WRITE_WINDOWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [15:0] addr,
    input  logic [15:0] end_addr,
    input  logic [7:0]  handler,
    output logic        done,
    output logic        table_hit,
    output logic [7:0]  handler_id,
    output logic [4:0]  fixed_target,
    output logic        table_full
);

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic             is_wr_reg, is_wr_next;
    logic             done_reg, done_next;
    logic             hit_reg, hit_next;
    logic [7:0]       id_reg, id_next;
    logic [4:0]       target_reg, target_next;
    logic             full_reg, full_next;
    pwad_pkg::token_t rd_launch_reg, rd_launch_next;
    pwad_pkg::token_t wr_launch_reg, wr_launch_next;
    pwad_pkg::token_t rd_result, wr_result, res;
    pwad_pkg::token_t launch;
    logic             accept;
    logic             clear;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign clear  = accept && (mode == pwad_pkg::MODE_CLEAR);

    always_comb
    begin
        launch          = '0;
        launch.vld      = 1'b1;
        launch.is_set   = (mode == pwad_pkg::MODE_SET_RD) || (mode == pwad_pkg::MODE_SET_WR);
        launch.addr     = addr;
        launch.end_addr = end_addr;
        launch.handler  = handler;
    end

    pwad_chain #(
        .DEPTH (READ_WINDOWS)
    ) u_rd_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .tok_in  (rd_launch_reg),
        .tok_out (rd_result)
    );

    pwad_chain #(
        .DEPTH (WRITE_WINDOWS)
    ) u_wr_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .tok_in  (wr_launch_reg),
        .tok_out (wr_result)
    );

    assign res = is_wr_reg ? wr_result : rd_result;

    always_comb
    begin
        state_next     = state_reg;
        is_wr_next     = is_wr_reg;
        done_next      = 1'b0;
        hit_next       = 1'b0;
        id_next        = '0;
        target_next    = pwad_pkg::TGT_OPEN;
        full_next      = 1'b0;
        rd_launch_next = '0;
        wr_launch_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    unique case (mode) inside
                        pwad_pkg::MODE_LOOKUP_RD, pwad_pkg::MODE_SET_RD:
                        begin
                            rd_launch_next = launch;
                            is_wr_next     = 1'b0;
                            state_next     = ST_WAIT;
                        end
                        pwad_pkg::MODE_LOOKUP_WR, pwad_pkg::MODE_SET_WR:
                        begin
                            wr_launch_next = launch;
                            is_wr_next     = 1'b1;
                            state_next     = ST_WAIT;
                        end
                        default:
                        begin
                            // clear and unused modes give an all-zero result
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (res.vld) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (res.is_set) begin
                        full_next = !res.hit && !res.appended;
                    end else if (res.hit) begin
                        hit_next = 1'b1;
                        id_next  = res.id;
                    end else begin
                        target_next = is_wr_reg ? pwad_pkg::fixed_write(res.addr)
                                                : pwad_pkg::fixed_read(res.addr);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            is_wr_reg     <= 1'b0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            id_reg        <= '0;
            target_reg    <= pwad_pkg::TGT_OPEN;
            full_reg      <= 1'b0;
            rd_launch_reg <= '0;
            wr_launch_reg <= '0;
        end else begin
            state_reg     <= state_next;
            is_wr_reg     <= is_wr_next;
            done_reg      <= done_next;
            hit_reg       <= hit_next;
            id_reg        <= id_next;
            target_reg    <= target_next;
            full_reg      <= full_next;
            rd_launch_reg <= rd_launch_next;
            wr_launch_reg <= wr_launch_next;
        end
    end

    assign done         = done_reg;
    assign table_hit    = hit_reg;
    assign handler_id   = id_reg;
    assign fixed_target = target_reg;
    assign table_full   = full_reg;

endmodule

// ===== design/pwad_cell.sv =====
module pwad_cell #(
    parameter int DEPTH = pwad_pkg::READ_WINDOWS_DEF,
    parameter int INDEX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  pwad_pkg::token_t             tok_in,
    output pwad_pkg::token_t             tok_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [15:0]      lo_reg, lo_next;
    logic [15:0]      hi_reg, hi_next;
    logic [7:0]       id_reg, id_next;
    pwad_pkg::token_t tok_reg, tok_next;
    logic             active;
    logic             at_tail;

    assign active  = (count > CW'(INDEX));
    assign at_tail = (count == CW'(INDEX));

    always_comb
    begin
        tok_next = tok_in;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        id_next  = id_reg;
        if (tok_in.vld) begin
            if (!tok_in.is_set) begin
                // later cells hold newer windows, so a later hit overrides
                if (active && tok_in.addr >= lo_reg && tok_in.addr <= hi_reg) begin
                    tok_next.hit = 1'b1;
                    tok_next.id  = id_reg;
                end
            end else begin
                if (active && lo_reg == tok_in.addr && hi_reg == tok_in.end_addr) begin
                    tok_next.hit = 1'b1;
                    id_next      = tok_in.handler;
                end else if (at_tail && !tok_in.hit) begin
                    // every live entry has been checked by now: append here
                    lo_next           = tok_in.addr;
                    hi_next           = tok_in.end_addr;
                    id_next           = tok_in.handler;
                    tok_next.appended = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        id_reg <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/pwad_chain.sv =====
module pwad_chain #(
    parameter int DEPTH = pwad_pkg::READ_WINDOWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  pwad_pkg::token_t tok_in,
    output pwad_pkg::token_t tok_out
);

    localparam int CW = $clog2(DEPTH + 1);

    pwad_pkg::token_t tok [DEPTH+1];
    logic [CW-1:0]    count_reg, count_next;

    assign tok[0] = tok_in;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        pwad_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (tok[DEPTH].vld && tok[DEPTH].is_set && tok[DEPTH].appended) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign tok_out = tok[DEPTH];

endmodule
